// ===== hw/rtl/rnf_pkg.sv =====
// Shared types and constants for the noise floor / SNR tracker.
package rnf_pkg;

  localparam int FLOOR_W = 9;
  localparam int SNR_W   = 8;

  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -9'sd150;
  localparam logic [7:0]                REPORT_BIAS = 8'd150;
  localparam logic [7:0]                HOLD_RESET  = 8'd2;

  // Per-channel minimum-hold count.
  localparam logic [7:0] HOLD_LIMIT [4] = '{8'd20, 8'd8, 8'd5, 8'd5};

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_PACKET = 2'd1,
    KIND_ACK    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CHANNEL = 2'd0,
    CFG_OFFSET  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] raw_rssi;
    logic signed [8:0] packet_rssi;
    logic [7:0]        reported_tx_snr;
  } item_t;

  typedef struct packed {
    logic signed [FLOOR_W-1:0] now;
    logic signed [FLOOR_W-1:0] next;
    logic                      updated;
  } floor_status_t;

  typedef struct packed {
    logic [SNR_W-1:0] last_snr;
    logic [SNR_W-1:0] avg_rx;
    logic [SNR_W-1:0] avg_tx;
  } snr_status_t;

endpackage

// ===== hw/rtl/rnf_if.sv =====
// Valid/ready channel interfaces for item and result words.
interface rnf_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [7:0] raw_rssi;
  logic signed [8:0] packet_rssi;
  logic [7:0]        reported_tx_snr;

  modport source (output valid, kind, raw_rssi, packet_rssi, reported_tx_snr, input ready);
  modport sink   (input valid, kind, raw_rssi, packet_rssi, reported_tx_snr, output ready);
endinterface

interface rnf_result_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] noise_floor;
  logic [7:0]        noise_report;
  logic [7:0]        last_snr;
  logic [7:0]        avg_rx_snr;
  logic [7:0]        avg_tx_snr;
  logic              floor_updated;

  modport source (output valid, noise_floor, noise_report, last_snr, avg_rx_snr, avg_tx_snr,
                  floor_updated, input ready);
  modport sink   (input valid, noise_floor, noise_report, last_snr, avg_rx_snr, avg_tx_snr,
                  floor_updated, output ready);
endinterface

// ===== hw/rtl/rnf_avg_div.sv =====
// Signed divide of the sample sum by the window length, truncating toward zero.
module rnf_avg_div
  import rnf_pkg::*;
#(
  parameter int SAMPLES = 10,
  parameter int SUM_W   = 13
) (
  input  logic signed [SUM_W-1:0]   sum,
  output logic signed [FLOOR_W-1:0] avg
);

  localparam int MAG_W = SUM_W - 1;
  localparam int K     = MAG_W + 4;   // exact for divisors below 16
  localparam int RW    = K + 1;
  localparam logic [RW-1:0] RECIP = RW'((2 ** K + SAMPLES - 1) / SAMPLES);

  logic [SUM_W-1:0]    neg;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W+RW-1:0] prod;
  logic [7:0]          quo;

  always_comb begin
    neg  = -sum;
    mag  = sum[SUM_W-1] ? neg[MAG_W-1:0] : sum[MAG_W-1:0];
    prod = {{RW{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP};
    quo  = prod[K+7:K];
    avg  = sum[SUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule

// ===== hw/rtl/rnf_floor.sv =====
// Noise floor path: sample accumulator, window minimum, hold countdown, floor.
module rnf_floor
  import rnf_pkg::*;
#(
  parameter int SAMPLES = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  item_t             word,
  input  logic [1:0]        channel_index,
  input  logic signed [7:0] rssi_offset,
  output floor_status_t     status
);

  localparam int SUM_W = $clog2(SAMPLES * 255 + 1) + 1;
  localparam int CNT_W = $clog2(SAMPLES + 1);

  logic signed [FLOOR_W-1:0] floor_value, floor_value_next;
  logic signed [FLOOR_W-1:0] window_minimum, window_minimum_next;
  logic signed [SUM_W-1:0]   sample_sum, sample_sum_next;
  logic [CNT_W-1:0]          sample_count, sample_count_next;
  logic [7:0]                hold_countdown, hold_countdown_next;

  logic signed [FLOOR_W-1:0] avg, min_tmp;
  logic signed [8:0]         sample;
  logic [7:0]                limit, cd_dec, cd_inc;
  logic                      updated;

  rnf_avg_div #(.SAMPLES(SAMPLES), .SUM_W(SUM_W)) u_div (
    .sum (sample_sum),
    .avg (avg)
  );

  always_comb begin
    floor_value_next    = floor_value;
    window_minimum_next = window_minimum;
    sample_sum_next     = sample_sum;
    sample_count_next   = sample_count;
    hold_countdown_next = hold_countdown;
    updated             = 1'b0;
    limit   = HOLD_LIMIT[channel_index];
    sample  = 9'(word.raw_rssi) - 9'(rssi_offset);
    min_tmp = (avg < window_minimum) ? avg : window_minimum;
    cd_dec  = hold_countdown - 8'd1;
    cd_inc  = hold_countdown + 8'd1;
    if (step) begin
      case (word.kind)
        KIND_SAMPLE: begin
          if (sample_count >= CNT_W'(SAMPLES)) begin
            sample_sum_next   = '0;
            sample_count_next = '0;
            if (cd_dec == 8'd0) begin
              floor_value_next    = (min_tmp == FLOOR_RESET) ? avg : min_tmp;
              window_minimum_next = '0;
              hold_countdown_next = limit;
              updated             = 1'b1;
            end else begin
              window_minimum_next = min_tmp;
              hold_countdown_next = cd_dec;
            end
          end else begin
            sample_sum_next   = sample_sum + SUM_W'(sample);
            sample_count_next = sample_count + CNT_W'(1);
          end
        end
        KIND_PACKET: begin
          hold_countdown_next = (cd_inc > limit) ? limit : cd_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_value    <= FLOOR_RESET;
      window_minimum <= FLOOR_RESET;
      sample_sum     <= '0;
      sample_count   <= '0;
      hold_countdown <= HOLD_RESET;
    end else begin
      floor_value    <= floor_value_next;
      window_minimum <= window_minimum_next;
      sample_sum     <= sample_sum_next;
      sample_count   <= sample_count_next;
      hold_countdown <= hold_countdown_next;
    end
  end

  assign status.now     = floor_value;
  assign status.next    = floor_value_next;
  assign status.updated = updated;

endmodule

// ===== hw/rtl/rnf_snr.sv =====
// Link SNR path: packet SNR against the floor and the two 3/4 running averages.
module rnf_snr
  import rnf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  item_t                     word,
  input  logic signed [FLOOR_W-1:0] floor_now,
  output snr_status_t               status
);

  logic [SNR_W-1:0] recent_snr, recent_snr_next;
  logic [SNR_W-1:0] rx_snr_average, rx_snr_average_next;
  logic [SNR_W-1:0] tx_snr_average, tx_snr_average_next;

  logic signed [9:0] diff;
  logic [SNR_W-1:0]  snr;
  logic [9:0]        rx_acc, tx_acc;

  always_comb begin
    recent_snr_next     = recent_snr;
    rx_snr_average_next = rx_snr_average;
    tx_snr_average_next = tx_snr_average;
    diff   = 10'(word.packet_rssi) - 10'(floor_now);
    snr    = diff[9] ? '0 : diff[7:0];
    rx_acc = 10'(rx_snr_average) * 10'd3 + 10'(snr);
    tx_acc = 10'(tx_snr_average) * 10'd3 + 10'(word.reported_tx_snr);
    if (step) begin
      case (word.kind)
        KIND_PACKET: begin
          recent_snr_next     = snr;
          rx_snr_average_next = rx_acc[9:2];
        end
        KIND_ACK: begin
          tx_snr_average_next = tx_acc[9:2];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_snr     <= '0;
      rx_snr_average <= '0;
      tx_snr_average <= '0;
    end else begin
      recent_snr     <= recent_snr_next;
      rx_snr_average <= rx_snr_average_next;
      tx_snr_average <= tx_snr_average_next;
    end
  end

  assign status.last_snr = recent_snr_next;
  assign status.avg_rx   = rx_snr_average_next;
  assign status.avg_tx   = tx_snr_average_next;

endmodule

// ===== hw/rtl/rssi_noise_floor_snr_tracker_unit.sv =====
// Top level of the RSSI noise floor and link SNR tracker.
//
// Every input word gives exactly one result word. A word is one of three kinds:
// an idle-receive RSSI sample tick, a downlink packet, or an uplink ack. Sample
// ticks accumulate (raw RSSI - rssi_offset) until SAMPLES_PER_AVERAGE samples
// are held; the next tick averages them (truncating toward zero), tracks the
// window minimum and decrements the hold countdown. When the countdown hits
// zero the floor is published (floor_updated = 1), the minimum restarts at 0
// and the countdown reloads from the per-channel table 20/8/5/5. Packets nudge
// the countdown up (clamped to the channel limit), compute SNR against the
// floor (0 below floor) and fold it into a 3/4-old running average; acks do
// the same for the uplink average. A word is registered at the input register,
// processed combinationally through the floor and SNR paths when it moves on,
// and lands in the result register, which offers its result word. The unit
// takes one word per cycle unless the result register waits on a stalled
// sink. While a finished word waits downstream, an empty input register can
// still take one word. Configuration (channel_index = index 0, rssi_offset =
// index 1) must be written only while the unit holds no word in flight; the
// unit itself does not enforce this.
module rssi_noise_floor_snr_tracker_unit
  import rnf_pkg::*;
#(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic        clk,
  input  logic        rst,
  rnf_item_if.sink    item,
  rnf_result_if.source result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [7:0]  wr_data
);

  // configuration registers
  logic [1:0]        channel_index;
  logic signed [7:0] rssi_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      rssi_offset   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_CHANNEL: channel_index <= wr_data[1:0];
        CFG_OFFSET:  rssi_offset   <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  item_t word;
  logic  word_valid;
  logic  step;

  // a word moves on when the result register is empty or being drained
  assign step       = word_valid && (!result.valid || result.ready);
  assign item.ready = !word_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (item.ready) begin
      word_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      word.kind            <= item.kind;
      word.raw_rssi        <= item.raw_rssi;
      word.packet_rssi     <= item.packet_rssi;
      word.reported_tx_snr <= item.reported_tx_snr;
    end
  end

  // processing paths
  floor_status_t floor_st;
  snr_status_t   snr_st;

  rnf_floor #(.SAMPLES(SAMPLES_PER_AVERAGE)) u_floor (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .word          (word),
    .channel_index (channel_index),
    .rssi_offset   (rssi_offset),
    .status        (floor_st)
  );

  rnf_snr u_snr (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (word),
    .floor_now (floor_st.now),
    .status    (snr_st)
  );

  // result register: state after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.noise_floor   <= floor_st.next;
      result.noise_report  <= floor_st.next[7:0] + REPORT_BIAS;
      result.last_snr      <= snr_st.last_snr;
      result.avg_rx_snr    <= snr_st.avg_rx;
      result.avg_tx_snr    <= snr_st.avg_tx;
      result.floor_updated <= floor_st.updated;
    end
  end

endmodule

// ===== sim/rssi_noise_floor_snr_tracker_unit_checker.sv =====
// Checker for the noise floor / SNR tracker: predicts each result word and compares.
`timescale 1ns / 1ps

module rssi_noise_floor_snr_tracker_unit_checker
  import rnf_pkg::*;
#(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic         clk,
  input  logic         rst,
  rnf_item_if          item,
  rnf_result_if        result,
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [7:0]   wr_data,
  output int           mismatches,
  output int           pending,
  output int           floors_published
);

  typedef struct packed {
    logic signed [8:0] noise_floor;
    logic [7:0]        noise_report;
    logic [7:0]        last_snr;
    logic [7:0]        avg_rx_snr;
    logic [7:0]        avg_tx_snr;
    logic              floor_updated;
  } tracker_word_t;

  tracker_word_t expected_words[$];

  // predicted tracker state
  logic [1:0]         channel;
  logic signed [7:0]  offset;
  logic signed [9:0]  floor_level;
  logic signed [12:0] window_sum;
  logic [3:0]         window_count;
  logic signed [9:0]  lowest_avg;
  logic [7:0]         hold_left;
  logic [7:0]         rx_avg;
  logic [7:0]         tx_avg;
  logic [7:0]         recent_snr;

  int mismatch_total = 0;
  int publish_total  = 0;
  int words_checked  = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] tracker mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("word %0d %s = %0d, expected %0d", words_checked, name, got,
                                want));
  endtask

  task automatic advance_tracker(input logic [1:0] kind, input logic signed [7:0] raw,
                                 input logic signed [8:0] prssi, input logic [7:0] rep);
    int            avg;
    int            diff;
    logic [7:0]    snr;
    logic [7:0]    lim;
    logic          updated;
    tracker_word_t w;
    updated = 1'b0;
    case (kind_t'(kind))
      KIND_SAMPLE: begin
        if (window_count >= SAMPLES_PER_AVERAGE) begin
          avg = (window_count != 0) ? int'(window_sum) / int'(window_count) : 0;
          window_sum   = '0;
          window_count = '0;
          if (avg < int'(lowest_avg)) lowest_avg = 10'(avg);
          hold_left = hold_left - 8'd1;
          if (hold_left == 8'd0) begin
            // untouched minimum means no window went below reset: take the fresh average
            floor_level = (lowest_avg == FLOOR_RESET) ? 10'(avg) : lowest_avg;
            lowest_avg  = '0;
            hold_left   = HOLD_LIMIT[channel];
            updated     = 1'b1;
            publish_total++;
          end
        end else begin
          window_sum   = 13'(int'(window_sum) + int'(raw) - int'(offset));
          window_count = window_count + 4'd1;
        end
      end
      KIND_PACKET: begin
        lim       = HOLD_LIMIT[channel];
        hold_left = hold_left + 8'd1;
        if (hold_left > lim) hold_left = lim;
        diff       = int'(prssi) - int'(floor_level);
        snr        = (diff < 0) ? 8'd0 : 8'(diff);
        recent_snr = snr;
        rx_avg     = 8'((int'(rx_avg) * 3 + int'(snr)) >> 2);
      end
      KIND_ACK: begin
        tx_avg = 8'((int'(tx_avg) * 3 + int'(rep)) >> 2);
      end
      default: ;
    endcase
    w.noise_floor   = floor_level[8:0];
    w.noise_report  = 8'(int'(floor_level) + int'(REPORT_BIAS));
    w.last_snr      = recent_snr;
    w.avg_rx_snr    = rx_avg;
    w.avg_tx_snr    = tx_avg;
    w.floor_updated = updated;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    tracker_word_t want;
    if (rst) begin
      channel      = '0;
      offset       = '0;
      floor_level  = 10'(FLOOR_RESET);
      window_sum   = '0;
      window_count = '0;
      lowest_avg   = 10'(FLOOR_RESET);
      hold_left    = HOLD_RESET;
      rx_avg       = '0;
      tx_avg       = '0;
      recent_snr   = '0;
      expected_words.delete();
    end else begin
      // results first: a word accepted now can't have its result out on the same edge
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d with nothing expected", words_checked));
        end else begin
          want = expected_words.pop_front();
          check_field("noise_floor", int'(result.noise_floor), int'(want.noise_floor));
          check_field("noise_report", int'(result.noise_report), int'(want.noise_report));
          check_field("last_snr", int'(result.last_snr), int'(want.last_snr));
          check_field("avg_rx_snr", int'(result.avg_rx_snr), int'(want.avg_rx_snr));
          check_field("avg_tx_snr", int'(result.avg_tx_snr), int'(want.avg_tx_snr));
          check_field("floor_updated", int'(result.floor_updated), int'(want.floor_updated));
        end
        words_checked++;
      end
      if (wr_en) begin
        case (cfg_reg_t'(wr_index))
          CFG_CHANNEL: channel = wr_data[1:0];
          CFG_OFFSET:  offset  = wr_data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        advance_tracker(item.kind, item.raw_rssi, item.packet_rssi, item.reported_tx_snr);
    end
    mismatches       <= mismatch_total;
    pending          <= expected_words.size();
    floors_published <= publish_total;
  end

endmodule

// ===== sim/rssi_noise_floor_snr_tracker_unit_tb.sv =====
// Testbench top for the noise floor / SNR tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rssi_noise_floor_snr_tracker_unit_tb;
  import rnf_pkg::*;

  localparam int SAMPLES_PER_AVERAGE = 10;
  localparam int RANDOM_PHASES       = 6;
  localparam int WORDS_PER_PHASE     = 170;
  // no word may go this long without moving on either channel
  localparam int STALL_LIMIT         = 2000;

  // kind 3 has no enum member; the block must treat it as a no-op
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  // register index past the end of the map; writes there must be dropped
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  // channel per random phase: all four, with 0 (longest hold) and 3 (shortest)
  localparam logic [1:0] PHASE_CHANNEL [RANDOM_PHASES] = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd3};

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;
  logic       sink_ready = 1'b0;

  int mismatches;
  int pending;
  int floors_published;

  rnf_item_if   item_ch ();
  rnf_result_if result_ch ();

  assign result_ch.ready = sink_ready;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rssi_noise_floor_snr_tracker_unit #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  rssi_noise_floor_snr_tracker_unit_checker #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .item            (item_ch),
    .result          (result_ch),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .floors_published(floors_published)
  );

  // Pacing knobs. A steady side never idles; they flip every so often so that
  // back-to-back stretches and gappy stretches both show up.
  bit steady_source = 1'b0;
  bit steady_sink   = 1'b0;
  int stall_left    = 0;

  int words_sent  = 0;
  int cur_offset  = 0;
  // where the block sits in its sample window: 0..9 accumulate, 10 is the averaging tick
  int sample_phase = 0;
  int window_mode  = 0;
  int window_base  = 0;

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side backpressure.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_length();
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog: any accepted word on either side resets the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles, giving up", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word after an optional gap and hold it until accepted. Leaves
  // valid high so a following call can stream without a bubble.
  task automatic send_item(input logic [1:0] k, input logic [7:0] raw, input logic [8:0] prssi,
                           input logic [7:0] rep);
    int gap;
    gap = steady_source ? 0 : gap_length();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.kind            <= k;
    item_ch.raw_rssi        <= raw;
    item_ch.packet_rssi     <= prssi;
    item_ch.reported_tx_snr <= rep;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
    if (k == KIND_SAMPLE) sample_phase = (sample_phase + 1) % (SAMPLES_PER_AVERAGE + 1);
  endtask

  // Registers change only with nothing in flight. Every word yields a result,
  // so an empty expectation queue means idle.
  // The pending count is registered, so step past the last accept first.
  // The unmapped index gets junk each time to prove it is ignored.
  task automatic set_config(input logic [1:0] ch, input logic signed [7:0] off);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= CFG_CHANNEL;
    wr_data  <= {6'($urandom), ch};
    @(posedge clk);
    wr_index <= CFG_OFFSET;
    wr_data  <= off;
    @(posedge clk);
    wr_index <= CFG_UNMAPPED;
    wr_data  <= 8'($urandom);
    @(posedge clk);
    wr_en      <= 1'b0;
    cur_offset  = int'(off);
  endtask

  // Random traffic. Most words are sample ticks so windows complete and the
  // hold countdown actually reaches zero; the packet share differs by phase
  // because packets push the countdown back up. Windows come in flavors:
  // fully random, near-constant, aimed at exactly -150 after the offset, and
  // pinned low to drag the window minimum down.
  task automatic run_random_phase(input int count);
    int         packet_pct;
    int         r;
    int         raw_v;
    int         prssi_v;
    int         target;
    logic [1:0] k;
    r = $urandom_range(0, 2);
    packet_pct = (r == 0) ? 2 : (r == 1) ? 6 : 25;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        steady_source = ($urandom_range(0, 4) == 0);
        steady_sink   = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < packet_pct) k = KIND_PACKET;
      else if (r < packet_pct + 8) k = KIND_ACK;
      else if (r < packet_pct + 11) k = KIND_UNUSED;
      else k = KIND_SAMPLE;

      raw_v = int'($urandom_range(0, 255)) - 128;
      if (k == KIND_SAMPLE) begin
        if (sample_phase == 0) begin
          window_mode = $urandom_range(0, 3);
          window_base = int'($urandom_range(0, 255)) - 128;
        end
        case (window_mode)
          1: begin
            raw_v = window_base + int'($urandom_range(0, 6)) - 3;
            if (raw_v > 127) raw_v = 127;
            if (raw_v < -128) raw_v = -128;
          end
          2: begin
            target = cur_offset - 150;
            if (target >= -128 && target <= 127) raw_v = target;
          end
          3: raw_v = int'($urandom_range(0, 28)) - 128;
          default: ;
        endcase
      end

      // half full-range, half in the band where floors usually sit
      if ($urandom_range(0, 1) == 0) prssi_v = int'($urandom_range(0, 511)) - 256;
      else prssi_v = int'($urandom_range(0, 260)) - 200;

      send_item(k, 8'(raw_v), 9'(prssi_v), 8'($urandom));
    end
    item_ch.valid <= 1'b0;
  endtask

  initial begin
    logic signed [7:0] off;
    rst                     <= 1'b1;
    item_ch.valid           <= 1'b0;
    item_ch.kind            <= '0;
    item_ch.raw_rssi        <= '0;
    item_ch.packet_rssi     <= '0;
    item_ch.reported_tx_snr <= '0;
    wr_en                   <= 1'b0;
    wr_index                <= '0;
    wr_data                 <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // Channel 3, offset at its top. Acks at both ends, then the unused kind.
    set_config(2'd3, 8'sd127);
    send_item(KIND_ACK, 8'd0, 9'd0, 8'hff);
    send_item(KIND_ACK, 8'd0, 9'd0, 8'h00);
    send_item(KIND_UNUSED, 8'h7f, 9'h0ff, 8'hff);
    // Window 1: raw 127 - 127 = 0 each, average 0; countdown 2 -> 1.
    repeat (SAMPLES_PER_AVERAGE + 1) send_item(KIND_SAMPLE, 8'sd127, 9'd0, 8'd0);
    // Window 2: nine zeros and one -255 -> sum -255, average -25 (truncated
    // toward zero). Countdown hits zero while the minimum is still the reset
    // value, so the floor becomes this fresh average.
    repeat (SAMPLES_PER_AVERAGE - 1) send_item(KIND_SAMPLE, 8'sd127, 9'd0, 8'd0);
    send_item(KIND_SAMPLE, -8'sd128, 9'd0, 8'd0);
    send_item(KIND_SAMPLE, 8'd0, 9'd0, 8'd0);
    // Top packet RSSI: difference 280 keeps only its low byte. Bottom one sits
    // below the floor and must give an SNR of zero.
    send_item(KIND_PACKET, 8'd0, 9'sd255, 8'd0);
    send_item(KIND_PACKET, 8'd0, -9'sd256, 8'd0);
    item_ch.valid <= 1'b0;

    // ---- random, one register setting per phase ----
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) off = -8'sd128;
      else if (p == 1) off = 8'sd0;
      else if (p == 3) off = 8'sd127;
      else off = 8'($urandom);
      set_config(PHASE_CHANNEL[p], off);
      run_random_phase(WORDS_PER_PHASE);
    end

    // drain, then let any stray result words show up
    steady_sink = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words over %0d register settings (all channels, offset extremes).",
             words_sent, RANDOM_PHASES + 1);
    $display("%0d noise floor publications checked, %0d mismatches.", floors_published,
             mismatches);
    if (pending != 0) $display("%0d expected result words never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
